FILE: design/mlft_pkg.sv
// shared types and constants of the mac learning forward table
`timescale 1ns / 1ps

package mlft_pkg;

  // cells reduced by one group stage
  localparam int unsigned GroupSize = 32;

  localparam int unsigned SwitchW = 64;
  localparam int unsigned MacW    = 48;
  localparam int unsigned PortW   = 32;
  localparam int unsigned ActionW = 2;

  localparam logic [MacW-1:0] MacBcast = {MacW{1'b1}};

  // result action codes
  localparam logic [ActionW-1:0] ActDrop    = 2'd0;
  localparam logic [ActionW-1:0] ActUnicast = 2'd1;
  localparam logic [ActionW-1:0] ActFlood   = 2'd2;

  // input beat: one packet event
  typedef struct packed {
    logic [SwitchW-1:0] switch_id;
    logic [MacW-1:0]    source_mac;
    logic [MacW-1:0]    dest_mac;
    logic [PortW-1:0]   in_port;
  } in_beat_t;

  // output beat: forwarding decision
  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [PortW-1:0]   out_port;
  } out_beat_t;

  // one table entry as held in a cell
  typedef struct packed {
    logic               valid;
    logic [SwitchW-1:0] switch_id;
    logic [MacW-1:0]    mac;
    logic [PortW-1:0]   port;
  } entry_t;

  // control broadcast to every cell
  typedef struct packed {
    logic cmp;
    logic shift;
    logic upd;
  } cell_ctrl_t;

  // registered summary of one group of cells
  typedef struct packed {
    logic             any_learn;
    logic             any_dest;
    logic [PortW-1:0] port;
  } grp_sum_t;

  // sequencer states
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StCmp  = 4'b0010,
    StRed  = 4'b0100,
    StFin  = 4'b1000
  } state_e;

endpackage

FILE: design/mlft_cell.sv
// one table entry with its key comparators, shifting into its neighbour
`timescale 1ns / 1ps

module mlft_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mlft_pkg::cell_ctrl_t ctrl_i,
  input  mlft_pkg::in_beat_t  key_i,
  input  mlft_pkg::entry_t    prev_i,
  output mlft_pkg::entry_t    entry_o,
  output logic                match_learn_o,
  output logic                match_dest_o
);

  logic                         valid_q;
  logic [mlft_pkg::SwitchW-1:0] switch_q;
  logic [mlft_pkg::MacW-1:0]    mac_q;
  logic [mlft_pkg::PortW-1:0]   port_q;
  logic                         match_learn_q, match_learn_d;
  logic                         match_dest_q, match_dest_d;

  // key compare against the stored entry
  assign match_learn_d = valid_q && (switch_q == key_i.switch_id) &&
                         (mac_q == key_i.source_mac);
  assign match_dest_d  = valid_q && (switch_q == key_i.switch_id) &&
                         (mac_q == key_i.dest_mac);

  // valid bit, cleared at reset, follows the shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= prev_i.valid;
    end
  end

  // entry payload: shift from the neighbour or update the port in place
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      switch_q <= prev_i.switch_id;
      mac_q    <= prev_i.mac;
      port_q   <= prev_i.port;
    end else if (ctrl_i.upd && match_learn_q) begin
      port_q <= key_i.in_port;
    end
  end

  // registered match flags
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp) begin
      match_learn_q <= match_learn_d;
      match_dest_q  <= match_dest_d;
    end
  end

  assign entry_o.valid     = valid_q;
  assign entry_o.switch_id = switch_q;
  assign entry_o.mac       = mac_q;
  assign entry_o.port      = port_q;
  assign match_learn_o     = match_learn_q;
  assign match_dest_o      = match_dest_q;

endmodule

FILE: design/mlft_group.sv
// registered reduction of the match flags and hit port over a group of cells
`timescale 1ns / 1ps

module mlft_group #(
  parameter int unsigned N = 32
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [N-1:0]                        match_learn_i,
  input  logic [N-1:0]                        match_dest_i,
  input  logic [N-1:0][mlft_pkg::PortW-1:0]   port_i,
  output mlft_pkg::grp_sum_t                  sum_o
);

  mlft_pkg::grp_sum_t sum_q, sum_d;

  // or of flags, and-or select of the destination port
  always_comb begin
    sum_d.any_learn = |match_learn_i;
    sum_d.any_dest  = |match_dest_i;
    sum_d.port      = '0;
    for (int unsigned i = 0; i < N; i++) begin
      sum_d.port = sum_d.port | (port_i[i] & {mlft_pkg::PortW{match_dest_i[i]}});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

FILE: design/mac_learning_forward_table.sv
// top level of the mac learning forward table
`timescale 1ns / 1ps

// Per-switch MAC learning and forwarding. Each input beat is one packet event and gives exactly
// one output beat: drop for a broadcast source, unicast to the learned port on a destination hit,
// flood on a miss. The table is a chain of ENTRIES cells, newest at cell 0; a new key shifts the
// chain by one and drops the tail entry, a known key updates its port in place. From acceptance
// to its result being loaded, an item steps through accept, compare in all cells at once,
// a registered or-reduction per group of 32 cells, then the final combine with the table
// write-back. in_ready_o is high only between items, and the result waits in an output register,
// so a stalled output delays only the write-back cycle. The table is empty right after reset;
// there is no clearing pass.
module mac_learning_forward_table #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mlft_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mlft_pkg::out_beat_t out_data_o
);

  localparam int unsigned NGroups = (ENTRIES + mlft_pkg::GroupSize - 1) / mlft_pkg::GroupSize;

  mlft_pkg::state_e   state_q, state_d;
  mlft_pkg::in_beat_t key_q;
  logic               out_valid_q, out_valid_d;
  mlft_pkg::out_beat_t out_q, out_d;

  mlft_pkg::cell_ctrl_t ctrl;
  mlft_pkg::entry_t     new_entry;
  mlft_pkg::entry_t     cell_entry [ENTRIES];
  logic [ENTRIES-1:0]   match_learn;
  logic [ENTRIES-1:0]   match_dest;
  logic [ENTRIES-1:0][mlft_pkg::PortW-1:0] cell_port;
  mlft_pkg::grp_sum_t   grp_sum [NGroups];

  logic                         in_fire;
  logic                         commit;
  logic                         any_learn, any_dest;
  logic [mlft_pkg::PortW-1:0]   dest_port;
  logic                         bcast, self_hit, evicted;

  assign in_ready_o = (state_q == mlft_pkg::StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign commit     = (state_q == mlft_pkg::StFin) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mlft_pkg::StIdle: if (in_fire) state_d = mlft_pkg::StCmp;
      mlft_pkg::StCmp:  state_d = mlft_pkg::StRed;
      mlft_pkg::StRed:  state_d = mlft_pkg::StFin;
      mlft_pkg::StFin:  if (commit) state_d = mlft_pkg::StIdle;
      default:          state_d = mlft_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlft_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // accepted beat held as the lookup key
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key_q <= in_data_i;
    end
  end

  // cell chain, new entry enters at cell 0
  assign new_entry.valid     = 1'b1;
  assign new_entry.switch_id = key_q.switch_id;
  assign new_entry.mac       = key_q.source_mac;
  assign new_entry.port      = key_q.in_port;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    mlft_pkg::entry_t prev;
    if (i == 0) begin : g_head
      assign prev = new_entry;
    end else begin : g_body
      assign prev = cell_entry[i-1];
    end
    mlft_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .key_i         (key_q),
      .prev_i        (prev),
      .entry_o       (cell_entry[i]),
      .match_learn_o (match_learn[i]),
      .match_dest_o  (match_dest[i])
    );
    assign cell_port[i] = cell_entry[i].port;
  end

  // group reduction stage
  for (genvar g = 0; g < NGroups; g++) begin : g_grp
    localparam int unsigned Lo = g * mlft_pkg::GroupSize;
    localparam int unsigned Sz = (ENTRIES - Lo < mlft_pkg::GroupSize) ?
                                 (ENTRIES - Lo) : mlft_pkg::GroupSize;
    mlft_group #(.N(Sz)) u_grp (
      .clk_i         (clk_i),
      .en_i          (state_q == mlft_pkg::StRed),
      .match_learn_i (match_learn[Lo+Sz-1:Lo]),
      .match_dest_i  (match_dest[Lo+Sz-1:Lo]),
      .port_i        (cell_port[Lo+Sz-1:Lo]),
      .sum_o         (grp_sum[g])
    );
  end

  // combine the group summaries
  always_comb begin
    any_learn = 1'b0;
    any_dest  = 1'b0;
    dest_port = '0;
    for (int unsigned g = 0; g < NGroups; g++) begin
      any_learn = any_learn | grp_sum[g].any_learn;
      any_dest  = any_dest | grp_sum[g].any_dest;
      dest_port = dest_port | grp_sum[g].port;
    end
  end

  // decision: learning runs before the lookup, so a new key evicts the tail first
  assign bcast    = (key_q.source_mac == mlft_pkg::MacBcast);
  assign self_hit = (key_q.dest_mac == key_q.source_mac);
  assign evicted  = !any_learn && match_dest[ENTRIES-1];

  always_comb begin
    if (bcast) begin
      out_d.action   = mlft_pkg::ActDrop;
      out_d.out_port = '0;
    end else if (self_hit) begin
      out_d.action   = mlft_pkg::ActUnicast;
      out_d.out_port = key_q.in_port;
    end else if (any_dest && !evicted) begin
      out_d.action   = mlft_pkg::ActUnicast;
      out_d.out_port = dest_port;
    end else begin
      out_d.action   = mlft_pkg::ActFlood;
      out_d.out_port = '0;
    end
  end

  // cell control
  assign ctrl.cmp   = (state_q == mlft_pkg::StCmp);
  assign ctrl.shift = commit && !bcast && !any_learn;
  assign ctrl.upd   = commit && !bcast && any_learn;

  // output register
  assign out_valid_d = commit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/mlft_checker.sv
// port-level checks of the mac learning forward table, bound to the top level
`timescale 1ns / 1ps

module mlft_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mlft_pkg::out_beat_t out_data_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // drop and flood carry no port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.action != mlft_pkg::ActUnicast) |-> out_data_o.out_port == '0)
    else $error("port set on a non-unicast result");

  // one item in flight: input stays closed while the item is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("input reopened before the item finished");

  // a fresh result is loaded as the block returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result appeared without the item completing");

endmodule

bind mac_learning_forward_table mlft_checker u_mlft_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: tb/sv/testbench.sv
// testbench for the mac learning forward table: directed probes then pooled random traffic
`timescale 1ns / 1ps

module testbench;

  localparam int TableDepth = 16;
  localparam int ClkPeriod  = 4;
  localparam int PhaseItems = 150;

  // one directed probe, with its result typed in where it is obvious
  typedef struct {
    mlft_pkg::in_beat_t  ev;
    bit                  known;
    mlft_pkg::out_beat_t want;
  } probe_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_ready_o;
  mlft_pkg::in_beat_t  in_data     = '0;
  logic                out_valid_o;
  logic                out_ready   = 1'b0;
  mlft_pkg::out_beat_t out_data_o;

  // own copy of the learning table, newest entry at index 0
  logic [mlft_pkg::SwitchW-1:0] tbl_switch [TableDepth];
  logic [mlft_pkg::MacW-1:0]    tbl_mac    [TableDepth];
  logic [mlft_pkg::PortW-1:0]   tbl_port   [TableDepth];
  logic                         tbl_valid  [TableDepth];

  mlft_pkg::out_beat_t decision_q[$];
  probe_t              probes[$];
  mlft_pkg::out_beat_t head_want;

  int n_fail    = 0;
  int n_events  = 0;
  int n_drop    = 0;
  int n_unicast = 0;
  int n_flood   = 0;
  int n_update  = 0;
  int n_evict   = 0;
  int burst_left = 0;
  int rx_tick   = 0;
  int rx_mode   = 0;

  mac_learning_forward_table #(
    .ENTRIES(TableDepth)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // hard stop for a hung run
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // position of a valid entry holding this key, or -1
  function automatic int find_entry(logic [mlft_pkg::SwitchW-1:0] sw,
                                    logic [mlft_pkg::MacW-1:0] mac);
    for (int i = 0; i < TableDepth; i++) begin
      if (tbl_valid[i] && tbl_switch[i] == sw && tbl_mac[i] == mac) return i;
    end
    return -1;
  endfunction

  // learn the source, then look up the destination
  task automatic forward_decision(input mlft_pkg::in_beat_t ev,
                                  output mlft_pkg::out_beat_t res);
    int slot;
    res = '0;
    if (ev.source_mac == mlft_pkg::MacBcast) begin
      res.action = mlft_pkg::ActDrop;
      n_drop++;
      return;
    end
    slot = find_entry(ev.switch_id, ev.source_mac);
    if (slot >= 0) begin
      tbl_port[slot] = ev.in_port;
      n_update++;
    end else begin
      if (tbl_valid[TableDepth-1]) n_evict++;
      for (int i = TableDepth - 1; i > 0; i--) begin
        tbl_switch[i] = tbl_switch[i-1];
        tbl_mac[i]    = tbl_mac[i-1];
        tbl_port[i]   = tbl_port[i-1];
        tbl_valid[i]  = tbl_valid[i-1];
      end
      tbl_switch[0] = ev.switch_id;
      tbl_mac[0]    = ev.source_mac;
      tbl_port[0]   = ev.in_port;
      tbl_valid[0]  = 1'b1;
    end
    slot = find_entry(ev.switch_id, ev.dest_mac);
    if (slot >= 0) begin
      res.action   = mlft_pkg::ActUnicast;
      res.out_port = tbl_port[slot];
      n_unicast++;
    end else begin
      res.action = mlft_pkg::ActFlood;
      n_flood++;
    end
  endtask

  task automatic add_probe(input logic [mlft_pkg::SwitchW-1:0] sw,
                           input logic [mlft_pkg::MacW-1:0] src,
                           input logic [mlft_pkg::MacW-1:0] dst,
                           input logic [mlft_pkg::PortW-1:0] port,
                           input bit known, input logic [mlft_pkg::ActionW-1:0] act,
                           input logic [mlft_pkg::PortW-1:0] oport);
    probe_t p;
    p.ev.switch_id       = sw;
    p.ev.source_mac      = src;
    p.ev.dest_mac        = dst;
    p.ev.in_port         = port;
    p.known              = known;
    p.want.action        = act;
    p.want.out_port      = oport;
    probes.push_back(p);
  endtask

  // present one beat from a falling edge and hold it until taken
  task automatic send_beat(input mlft_pkg::in_beat_t ev, input bit known,
                           input mlft_pkg::out_beat_t want);
    mlft_pkg::out_beat_t pred;
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (!in_ready_o);
    forward_decision(ev, pred);
    decision_q.push_back(known ? want : pred);
    n_events++;
    @(negedge clk);
  endtask

  // bursts of random length with random gaps
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(negedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 20) : $urandom_range(10, 0);
    end
  endtask

  // hold off until every outstanding result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (decision_q.size() != 0) @(negedge clk);
  endtask

  // receiver stall pattern in one of four randomly picked modes
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 64 == 0) rx_mode = $urandom_range(3, 0);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(1, 0));
      2: out_ready <= ($urandom_range(3, 0) == 0);
      default: out_ready <= (rx_tick % 5 < 3);
    endcase
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid_o && out_ready) begin
      if (decision_q.size() == 0) begin
        $error("result beat with nothing expected: action %0d out_port %0h",
               out_data_o.action, out_data_o.out_port);
        n_fail++;
      end else begin
        head_want = decision_q.pop_front();
        if (out_data_o.action !== head_want.action) begin
          $error("action: expected %0d, got %0d", head_want.action, out_data_o.action);
          n_fail++;
        end
        if (out_data_o.out_port !== head_want.out_port) begin
          $error("out_port: expected %0h, got %0h", head_want.out_port, out_data_o.out_port);
          n_fail++;
        end
      end
    end
  end

  initial begin
    logic [mlft_pkg::SwitchW-1:0] sw_pool [3];
    logic [mlft_pkg::MacW-1:0]    mac_pool [40];
    mlft_pkg::in_beat_t           ev;
    int                           pool_n;
    int                           pick;

    for (int i = 0; i < TableDepth; i++) begin
      tbl_switch[i] = '0;
      tbl_mac[i]    = '0;
      tbl_port[i]   = '0;
      tbl_valid[i]  = 1'b0;
    end

    // directed probes: empty table, broadcast source, same source and destination,
    // extremes, in-place update, broadcast destination, table full and eviction
    add_probe(64'd0, 48'd1, 48'd0, 32'd5, 1, mlft_pkg::ActFlood, 32'd0);
    add_probe(64'd0, mlft_pkg::MacBcast, 48'd1, 32'd7, 1, mlft_pkg::ActDrop, 32'd0);
    add_probe('1, 48'd0, 48'd0, 32'hFFFF_FF00, 1, mlft_pkg::ActUnicast, 32'hFFFF_FF00);
    add_probe(64'd0, 48'd2, 48'd1, 32'd0, 1, mlft_pkg::ActUnicast, 32'd5);
    add_probe(64'd1, 48'd3, 48'd1, 32'd3, 1, mlft_pkg::ActFlood, 32'd0);
    add_probe(64'd0, 48'd1, 48'd2, 32'd9, 1, mlft_pkg::ActUnicast, 32'd0);
    add_probe(64'd0, 48'd2, 48'd1, 32'd0, 1, mlft_pkg::ActUnicast, 32'd9);
    add_probe(64'd0, 48'hFFFF_FFFF_FFFE, mlft_pkg::MacBcast, 32'd1, 1,
              mlft_pkg::ActFlood, 32'd0);
    add_probe('1, 48'hAAAA_AAAA_AAAA, 48'd0, 32'h5555_5555, 1,
              mlft_pkg::ActUnicast, 32'hFFFF_FF00);
    // ten new keys fill the table, the oldest key now sits at the tail
    for (int i = 0; i < 10; i++) begin
      add_probe(64'd2, 48'h100 + i, 48'h100 + ((i == 0) ? 0 : i - 1), 32'h1000 + i,
                0, mlft_pkg::ActFlood, 32'd0);
    end
    // the new key evicts the oldest before the lookup
    add_probe(64'd3, 48'h600, 48'd1, 32'd6, 1, mlft_pkg::ActFlood, 32'd0);
    add_probe(64'd0, 48'd2, 48'd2, 32'd4, 1, mlft_pkg::ActUnicast, 32'd4);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (probes[r]) begin
      send_beat(probes[r].ev, probes[r].known, probes[r].want);
      if (r == probes.size() - 1) drain();
      else pace();
    end

    // random phases over key pools of growing size, so hits, updates and evictions mix
    for (int ph = 0; ph < 3; ph++) begin
      pool_n     = (ph == 0) ? 6 : (ph == 1) ? 12 : 40;
      sw_pool[0] = {$urandom, $urandom};
      sw_pool[1] = (ph == 1) ? '1 : '0;
      sw_pool[2] = {$urandom, $urandom};
      foreach (mac_pool[k]) mac_pool[k] = 48'({$urandom, $urandom});
      for (int n = 0; n < PhaseItems; n++) begin
        ev.switch_id  = sw_pool[$urandom_range(2, 0)];
        ev.source_mac = mac_pool[$urandom_range(pool_n - 1, 0)];
        ev.dest_mac   = mac_pool[$urandom_range(pool_n - 1, 0)];
        ev.in_port    = $urandom_range(32'hFFFF_FF00, 0);
        pick = $urandom_range(99, 0);
        if (pick < 5) begin
          ev.source_mac = mlft_pkg::MacBcast;
        end else if (pick < 15) begin
          ev.switch_id  = {$urandom, $urandom};
          ev.source_mac = 48'({$urandom, $urandom});
        end
        pick = $urandom_range(99, 0);
        if (pick < 8) ev.dest_mac = 48'({$urandom, $urandom});
        else if (pick < 14) ev.dest_mac = mlft_pkg::MacBcast;
        send_beat(ev, 1'b0, '0);
        if (n == PhaseItems - 1) drain();
        else pace();
      end
    end

    repeat (10) @(posedge clk);
    $display("run covered %0d packet events: %0d drop, %0d unicast, %0d flood",
             n_events, n_drop, n_unicast, n_flood);
    $display("table activity: %0d in-place updates, %0d evictions", n_update, n_evict);
    if (n_fail == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
